>>> src/bmm_pkg.sv
// Shared constants, codes and types for the bitap mismatch matcher.
package bmm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int MAX_ROWS    = 8;

    localparam int SYM_W     = 8;
    localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
    localparam int MM_W      = 3;
    localparam int COUNTER_W = 33;
    localparam int START_W   = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_START   = 2'd1,
        CMD_SUBJECT = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MAX_MISMATCHES = 1'b0,
        REG_MATCH_EXACT    = 1'b1
    } cfg_reg_t;

    typedef logic [MAX_PATTERN-1:0] pos_mask_t;

    // Pattern status seen by the row logic.
    typedef struct packed {
        pos_mask_t        active;   // low length bits set
        logic [LEN_W-1:0] length;
    } pat_info_t;

endpackage

>>> src/bitap_mismatch_matcher.sv
// Top level: shift-or matcher with up to k mismatches, rows and result queue.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: cmd, first_symbol; tdata: symbol
//  m_      | out | m_tvalid/m_tready  | tdata: match_start, mismatches
//  cfg_    | in  | cfg_wr_en          | cfg_addr: register, cfg_wdata: value
//
// One beat per cycle while s_tready is high: each beat is decoded, the mismatch
// mask built and all rows stepped in the cycle it is accepted; a result is
// written into the result queue on the next edge.
// A two-entry result queue keeps s_tready high while one result waits; it
// drops only when both entries are full. aresetn (sync, active low) clears
// rows, counter, pattern length, registers and the queue.
module bitap_mismatch_matcher (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input beats
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [7:0] symbol
    input  logic [2:0]                     s_tuser,  // [1:0] cmd, [2] first_symbol
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [39:0]                    m_tdata,  // [31:0] match_start,
                                                     // [34:32] mismatches, rest 0
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [bmm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bmm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    typedef struct packed {
        logic signed [bmm_pkg::START_W-1:0] match_start;
        logic [bmm_pkg::MM_W-1:0]           mismatches;
    } result_t;

    // ---------------- configuration ----------------
    logic [bmm_pkg::MM_W-1:0] max_mm_reg;
    logic                     exact_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_mm_reg <= '0;
            exact_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (bmm_pkg::cfg_reg_t'(cfg_addr))
                bmm_pkg::REG_MAX_MISMATCHES: max_mm_reg <= cfg_wdata[bmm_pkg::MM_W-1:0];
                bmm_pkg::REG_MATCH_EXACT:    exact_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- input decode ----------------
    logic          accept;
    bmm_pkg::cmd_t cmd;

    assign accept = s_tvalid && s_tready;
    assign cmd    = bmm_pkg::cmd_t'(s_tuser[1:0]);

    // ---------------- pattern ----------------
    bmm_pkg::pos_mask_t miss_mask;
    bmm_pkg::pat_info_t pat;

    bmm_pattern u_pattern (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .append_en    (accept && (cmd == bmm_pkg::CMD_APPEND)),
        .first_symbol (s_tuser[2]),
        .symbol       (s_tdata[bmm_pkg::SYM_W-1:0]),
        .match_exact  (exact_reg),
        .miss_mask    (miss_mask),
        .info         (pat)
    );

    // ---------------- rows and position counter ----------------
    bmm_pkg::pos_mask_t row_reg  [bmm_pkg::MAX_ROWS];
    bmm_pkg::pos_mask_t row_next [bmm_pkg::MAX_ROWS];
    bmm_pkg::pos_mask_t shifted  [bmm_pkg::MAX_ROWS];
    bmm_pkg::pos_mask_t stepped  [bmm_pkg::MAX_ROWS];
    logic [bmm_pkg::COUNTER_W-1:0] counter_reg, counter_next, counter_step;
    bmm_pkg::pos_mask_t pm;
    logic [bmm_pkg::MAX_ROWS-1:0]  row_used;
    logic                          hit;
    logic [bmm_pkg::MM_W-1:0]      hit_row;

    // tick: every position counts as a mismatch
    assign pm = (cmd == bmm_pkg::CMD_TICK) ? '1 : miss_mask;
    assign counter_step = counter_reg + bmm_pkg::COUNTER_W'(1);

    // Each row steps from its own shift, limited by the row below (old and new).
    always_comb begin
        for (int e = 0; e < bmm_pkg::MAX_ROWS; e++) begin
            shifted[e]  = row_reg[e] >> 1;
            row_used[e] = (e <= int'(max_mm_reg));
        end
        stepped[0] = shifted[0] | pm;
        for (int e = 1; e < bmm_pkg::MAX_ROWS; e++) begin
            stepped[e] = (shifted[e] | pm) & shifted[e-1] & stepped[e-1];
        end
    end

    // Lowest used row whose bit 0 cleared marks a match.
    always_comb begin
        hit     = 1'b0;
        hit_row = '0;
        for (int e = bmm_pkg::MAX_ROWS - 1; e >= 0; e--) begin
            if (row_used[e] && !stepped[e][0]) begin
                hit     = 1'b1;
                hit_row = bmm_pkg::MM_W'(e);
            end
        end
        if (pat.length == '0) begin
            hit = 1'b0;
        end
    end

    always_comb begin
        for (int e = 0; e < bmm_pkg::MAX_ROWS; e++) begin
            row_next[e] = row_reg[e];
        end
        counter_next = counter_reg;
        if (accept) begin
            unique case (cmd)
                bmm_pkg::CMD_APPEND: ;
                bmm_pkg::CMD_START: begin
                    for (int e = 0; e < bmm_pkg::MAX_ROWS; e++) begin
                        row_next[e] = pat.active >> e;
                    end
                    counter_next = bmm_pkg::COUNTER_W'(1)
                                 - bmm_pkg::COUNTER_W'(pat.length);
                end
                bmm_pkg::CMD_SUBJECT, bmm_pkg::CMD_TICK: begin
                    for (int e = 0; e < bmm_pkg::MAX_ROWS; e++) begin
                        if (row_used[e]) begin
                            row_next[e] = stepped[e];
                        end
                    end
                    counter_next = counter_step;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < bmm_pkg::MAX_ROWS; e++) begin
                row_reg[e] <= '0;
            end
            counter_reg <= '0;
        end else begin
            for (int e = 0; e < bmm_pkg::MAX_ROWS; e++) begin
                row_reg[e] <= row_next[e];
            end
            counter_reg <= counter_next;
        end
    end

    // ---------------- result queue (two entries, head drives m_) ----------------
    result_t     new_res;
    result_t     head_reg, head_next, tail_reg, tail_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign new_res.match_start = counter_step[bmm_pkg::START_W-1:0];
    assign new_res.mismatches  = hit_row;

    assign push = accept && hit
               && ((cmd == bmm_pkg::CMD_SUBJECT) || (cmd == bmm_pkg::CMD_TICK));
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        unique case (count_reg)
            2'd0: begin
                if (push) begin
                    head_next  = new_res;
                    count_next = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    head_next = new_res;
                end else if (push) begin
                    tail_next  = new_res;
                    count_next = 2'd2;
                end else if (pop) begin
                    count_next = 2'd0;
                end
            end
            default: begin
                // full: no push possible, s_tready is low
                if (pop) begin
                    head_next  = tail_reg;
                    count_next = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign s_tready = (count_reg != 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {5'd0, head_reg.mismatches, head_reg.match_start};

endmodule

>>> src/bmm_pattern.sv
// Pattern store as a symbol shift line, plus per-position mismatch mask.
module bmm_pattern (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      append_en,
    input  logic                      first_symbol,
    input  logic [bmm_pkg::SYM_W-1:0] symbol,
    input  logic                      match_exact,
    output bmm_pkg::pos_mask_t        miss_mask,
    output bmm_pkg::pat_info_t        info
);

    // Entry j holds pattern position length-1-j, so it lines up with row bit j.
    logic [bmm_pkg::SYM_W-1:0] store_reg [bmm_pkg::MAX_PATTERN];
    bmm_pkg::pos_mask_t        active_reg, active_next;
    logic [bmm_pkg::LEN_W-1:0] length_reg, length_next;
    logic                      shift_en;

    always_comb begin
        active_next = active_reg;
        length_next = length_reg;
        shift_en    = 1'b0;
        if (append_en) begin
            if (first_symbol) begin
                active_next = bmm_pkg::pos_mask_t'(1);
                length_next = bmm_pkg::LEN_W'(1);
                shift_en    = 1'b1;
            end else if (length_reg < bmm_pkg::LEN_W'(bmm_pkg::MAX_PATTERN)) begin
                active_next = {active_reg[bmm_pkg::MAX_PATTERN-2:0], 1'b1};
                length_next = length_reg + bmm_pkg::LEN_W'(1);
                shift_en    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            length_reg <= '0;
        end else begin
            active_reg <= active_next;
            length_reg <= length_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            store_reg[0] <= symbol;
            for (int j = 1; j < bmm_pkg::MAX_PATTERN; j++) begin
                store_reg[j] <= store_reg[j-1];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < bmm_pkg::MAX_PATTERN; j++) begin
            if (match_exact) begin
                miss_mask[j] = active_reg[j] & (store_reg[j] != symbol);
            end else begin
                miss_mask[j] = active_reg[j] & ((store_reg[j] & symbol) == '0);
            end
        end
    end

    assign info.active = active_reg;
    assign info.length = length_reg;

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Testbench for bitap_mismatch_matcher: directed and random beat streams checked by a predictor.
module tb;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 4;    // extra wait after the last expected match has been seen

    // One expected match as it should appear on m_tdata.
    typedef struct packed {
        logic signed [bmm_pkg::START_W-1:0] start;
        logic [bmm_pkg::MM_W-1:0]           mism;
    } match_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;   // [7:0] symbol
    logic [2:0]                     s_tuser   = '0;   // [1:0] cmd, [2] first_symbol
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [39:0]                    m_tdata;          // [31:0] match_start, [34:32] mismatches
    logic                           cfg_wr_en = 1'b0;
    logic [bmm_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [bmm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor state: a private copy of pattern, rows, counter and registers.
    logic [bmm_pkg::SYM_W-1:0]       pat_syms [bmm_pkg::MAX_PATTERN];
    logic [bmm_pkg::LEN_W-1:0]       pat_len   = '0;
    logic [bmm_pkg::MAX_PATTERN-1:0] row_state [bmm_pkg::MAX_ROWS];
    logic [bmm_pkg::COUNTER_W-1:0]   start_cnt = '0;
    logic [bmm_pkg::MM_W-1:0]        cfg_k     = '0;
    logic                            cfg_exact = 1'b1;
    match_t                          expected_matches [$];

    // Symbols favored by the random stimulus so that matches actually happen.
    logic [bmm_pkg::SYM_W-1:0] search_alpha [4];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int beats_sent    = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    bitap_mismatch_matcher i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Receiver backpressure, changed at the falling edge only.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic flag_mismatch(string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Mismatch mask for one subject symbol: bit j covers pattern position len-1-j.
    function automatic logic [bmm_pkg::MAX_PATTERN-1:0] miss_mask(
        logic [bmm_pkg::SYM_W-1:0] sym);
        logic [bmm_pkg::MAX_PATTERN-1:0] m;
        logic                            miss;
        m = '0;
        for (int i = 0; i < bmm_pkg::MAX_PATTERN; i++) begin
            if (i < pat_len) begin
                miss = cfg_exact ? (pat_syms[i] != sym) : ((pat_syms[i] & sym) == '0);
                m = {m[bmm_pkg::MAX_PATTERN-2:0], miss};
            end
        end
        return m;
    endfunction

    // Advance the predictor by one accepted beat; queue the match it causes, if any.
    task automatic bitap_advance(bmm_pkg::cmd_t cmd, logic first,
                                 logic [bmm_pkg::SYM_W-1:0] sym);
        logic [bmm_pkg::MAX_PATTERN-1:0] pm;
        logic [bmm_pkg::MAX_PATTERN-1:0] prev_sh;
        logic [bmm_pkg::MAX_PATTERN-1:0] cur_sh;
        logic [bmm_pkg::MAX_PATTERN-1:0] r;
        int                              nrows;
        logic                            found;
        match_t                          hit;
        found = 1'b0;
        case (cmd)
            bmm_pkg::CMD_APPEND: begin
                if (first) pat_len = '0;
                // full pattern: the symbol is dropped
                if (pat_len < bmm_pkg::MAX_PATTERN) begin
                    pat_syms[pat_len] = sym;
                    pat_len = pat_len + 1'b1;
                end
            end
            bmm_pkg::CMD_START: begin
                r = (pat_len >= bmm_pkg::MAX_PATTERN)
                  ? '1
                  : ((bmm_pkg::MAX_PATTERN'(1) << pat_len) - bmm_pkg::MAX_PATTERN'(1));
                for (int e = 0; e < bmm_pkg::MAX_ROWS; e++) begin
                    row_state[e] = r;
                    r = r >> 1;
                end
                start_cnt = bmm_pkg::COUNTER_W'(1) - bmm_pkg::COUNTER_W'(pat_len);
            end
            default: begin
                // a past-end tick counts every position as a mismatch
                pm = (cmd == bmm_pkg::CMD_SUBJECT) ? miss_mask(sym) : '1;
                nrows = (int'(cfg_k) + 1 > bmm_pkg::MAX_ROWS) ? bmm_pkg::MAX_ROWS
                                                              : int'(cfg_k) + 1;
                cur_sh = row_state[0] >> 1;
                row_state[0] = cur_sh | pm;
                for (int e = 1; e < nrows; e++) begin
                    prev_sh = cur_sh;
                    cur_sh = row_state[e] >> 1;
                    row_state[e] = (cur_sh | pm) & prev_sh & row_state[e-1];
                end
                start_cnt = start_cnt + 1'b1;
                // empty pattern never reports
                if (pat_len != 0) begin
                    for (int e = 0; e < nrows; e++) begin
                        if (!found && !row_state[e][0]) begin
                            found = 1'b1;
                            hit.start = start_cnt[bmm_pkg::START_W-1:0];
                            hit.mism  = bmm_pkg::MM_W'(e);
                        end
                    end
                    if (found) expected_matches.push_back(hit);
                end
            end
        endcase
    endtask

    // Drive one beat, with optional sender idle cycles ahead of it.
    task automatic send_beat(bmm_pkg::cmd_t cmd, logic first,
                             logic [bmm_pkg::SYM_W-1:0] sym);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= {first, cmd};
        s_tdata  <= sym;
        do @(posedge aclk); while (!s_tready);
        bitap_advance(cmd, first, sym);
        beats_sent++;
    endtask

    // Drop valid and wait until every queued match has been seen.
    task automatic go_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(bmm_pkg::cfg_reg_t idx, logic [bmm_pkg::CFG_DATA_W-1:0] val);
        go_quiet();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            bmm_pkg::REG_MAX_MISMATCHES: cfg_k = val;
            bmm_pkg::REG_MATCH_EXACT:    cfg_exact = val[0];
            default: ;
        endcase
    endtask

    // Symbol biased toward the alphabet and the stored pattern.
    function automatic logic [bmm_pkg::SYM_W-1:0] random_symbol();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return search_alpha[$urandom_range(0, 3)];
        if (pick < 70 && pat_len != 0) return pat_syms[$urandom_range(0, int'(pat_len) - 1)];
        return bmm_pkg::SYM_W'($urandom_range(0, 255));
    endfunction

    function automatic int urandom_bit();
        return $urandom_range(0, 1);
    endfunction

    // Checker: every accepted result beat against the oldest expectation.
    always @(posedge aclk) begin : result_check
        match_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_matches.size() == 0) begin
                flag_mismatch($sformatf("unexpected result start %0d mismatches %0d",
                                        $signed(m_tdata[31:0]), m_tdata[34:32]));
            end else begin
                want = expected_matches.pop_front();
                if (m_tdata[31:0] !== want.start)
                    flag_mismatch($sformatf("match_start %0d, want %0d",
                                            $signed(m_tdata[31:0]), want.start));
                if (m_tdata[34:32] !== want.mism)
                    flag_mismatch($sformatf("mismatches %0d, want %0d",
                                            m_tdata[34:32], want.mism));
                if (m_tdata[39:35] !== '0)
                    flag_mismatch($sformatf("padding bits %b not zero", m_tdata[39:35]));
            end
        end
    end

    // Right after reset the pattern is empty: rows advance, nothing reported.
    task automatic test_empty_pattern();
        send_beat(bmm_pkg::CMD_START, 1'b0, 8'h00);
        send_beat(bmm_pkg::CMD_SUBJECT, 1'b0, 8'h00);
        send_beat(bmm_pkg::CMD_SUBJECT, 1'b1, 8'hFF);
        send_beat(bmm_pkg::CMD_TICK, 1'b0, 8'hFF);
    endtask

    // Reset settings (k = 0, exact), extreme symbol values.
    task automatic test_exact_extremes();
        send_beat(bmm_pkg::CMD_APPEND, 1'b1, 8'h00);
        send_beat(bmm_pkg::CMD_APPEND, 1'b0, 8'hFF);
        send_beat(bmm_pkg::CMD_START, 1'b0, 8'h00);
        send_beat(bmm_pkg::CMD_SUBJECT, 1'b0, 8'h00);
        send_beat(bmm_pkg::CMD_SUBJECT, 1'b0, 8'hFF);
        send_beat(bmm_pkg::CMD_SUBJECT, 1'b0, 8'hFF);
        send_beat(bmm_pkg::CMD_SUBJECT, 1'b1, 8'h00);
        send_beat(bmm_pkg::CMD_SUBJECT, 1'b0, 8'hFF);
        send_beat(bmm_pkg::CMD_TICK, 1'b0, 8'h00);
    endtask

    // Mismatches allowed: overhang at the subject start and past the end via ticks.
    task automatic test_overhang_ticks();
        write_reg(bmm_pkg::REG_MAX_MISMATCHES, 3'd2);
        send_beat(bmm_pkg::CMD_APPEND, 1'b1, 8'hA5);
        send_beat(bmm_pkg::CMD_APPEND, 1'b0, 8'h5A);
        send_beat(bmm_pkg::CMD_APPEND, 1'b0, 8'h3C);
        send_beat(bmm_pkg::CMD_START, 1'b0, 8'h00);
        send_beat(bmm_pkg::CMD_SUBJECT, 1'b0, 8'h3C);
        send_beat(bmm_pkg::CMD_SUBJECT, 1'b0, 8'hA5);
        send_beat(bmm_pkg::CMD_TICK, 1'b0, 8'h00);
        send_beat(bmm_pkg::CMD_TICK, 1'b1, 8'h00);
        send_beat(bmm_pkg::CMD_TICK, 1'b0, 8'h00);
    endtask

    // Code mode with all rows in use; upper wdata bits set on the mode write.
    task automatic test_code_mode();
        write_reg(bmm_pkg::REG_MATCH_EXACT, 3'b110);
        write_reg(bmm_pkg::REG_MAX_MISMATCHES, 3'd7);
        send_beat(bmm_pkg::CMD_APPEND, 1'b1, 8'h01);
        send_beat(bmm_pkg::CMD_APPEND, 1'b0, 8'h80);
        send_beat(bmm_pkg::CMD_START, 1'b0, 8'h00);
        send_beat(bmm_pkg::CMD_SUBJECT, 1'b0, 8'h81);
        send_beat(bmm_pkg::CMD_SUBJECT, 1'b0, 8'h00);
        send_beat(bmm_pkg::CMD_SUBJECT, 1'b0, 8'h80);
    endtask

    // Pattern filled to the limit and then overfilled; dropped symbols must not count.
    task automatic test_full_pattern();
        write_reg(bmm_pkg::REG_MATCH_EXACT, 3'b001);
        write_reg(bmm_pkg::REG_MAX_MISMATCHES, 3'd1);
        search_alpha[0] = 8'h41;
        search_alpha[1] = 8'h43;
        search_alpha[2] = 8'h41;
        search_alpha[3] = 8'h43;
        for (int i = 0; i < bmm_pkg::MAX_PATTERN + 2; i++)
            send_beat(bmm_pkg::CMD_APPEND, i == 0, search_alpha[$urandom_range(0, 1)]);
        send_beat(bmm_pkg::CMD_START, 1'b0, 8'h00);
        for (int i = 0; i < bmm_pkg::MAX_PATTERN; i++)
            send_beat(bmm_pkg::CMD_SUBJECT, 1'b0, pat_syms[i]);
        for (int i = 0; i < 12; i++)
            send_beat(bmm_pkg::CMD_SUBJECT, 1'b0, search_alpha[$urandom_range(0, 1)]);
        for (int i = 0; i < 4; i++)
            send_beat(bmm_pkg::CMD_TICK, 1'b0, 8'h00);
    endtask

    // One search: load a pattern, usually start, stream a subject with planted copies, then ticks.
    task automatic run_search();
        int                        pick;
        int                        plen;
        int                        slen;
        logic [bmm_pkg::SYM_W-1:0] sym;
        for (int i = 0; i < 4; i++) search_alpha[i] = bmm_pkg::SYM_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 85)      plen = $urandom_range(1, 6);
        else if (pick < 97) plen = $urandom_range(7, 20);
        else plen = $urandom_range(bmm_pkg::MAX_PATTERN - 4, bmm_pkg::MAX_PATTERN + 2);
        // now and then keep appending to the old pattern, or restart mid-load
        for (int i = 0; i < plen; i++)
            send_beat(bmm_pkg::CMD_APPEND,
                      (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0),
                      random_symbol());
        if ($urandom_range(0, 19) != 0)
            send_beat(bmm_pkg::CMD_START, 1'(urandom_bit()), random_symbol());
        slen = $urandom_range(4, 30);
        for (int i = 0; i < slen; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                // planted copy, a few positions replaced
                for (int j = 0; j < int'(pat_len); j++) begin
                    sym = ($urandom_range(0, 99) < 15) ? random_symbol() : pat_syms[j];
                    send_beat(bmm_pkg::CMD_SUBJECT, 1'(urandom_bit()), sym);
                end
            end else if (pick < 23) begin
                // pattern changed during the search
                send_beat(bmm_pkg::CMD_APPEND, 1'b0, random_symbol());
            end else if (pick < 25) begin
                send_beat(bmm_pkg::CMD_START, 1'b0, random_symbol());
            end else begin
                send_beat(bmm_pkg::CMD_SUBJECT, 1'(urandom_bit()), random_symbol());
            end
        end
        for (int i = $urandom_range(0, int'(pat_len) + 1); i > 0; i--)
            send_beat(bmm_pkg::CMD_TICK, 1'(urandom_bit()),
                      bmm_pkg::SYM_W'($urandom_range(0, 255)));
    endtask

    // Random searches under the given idle and stall rates, with register changes every third search.
    task automatic test_random_traffic(int sender_idle, int rx_stall, int n_beats);
        int stop_at;
        int nsearch;
        int pick;
        stop_at = beats_sent + n_beats;
        nsearch = 0;
        send_idle_pct = sender_idle;
        stall_pct     = rx_stall;
        while (beats_sent < stop_at) begin
            if (nsearch % 3 == 0) begin
                pick = $urandom_range(0, 3);
                write_reg(bmm_pkg::REG_MAX_MISMATCHES,
                          (pick == 0) ? 3'd0 : (pick == 1) ? 3'd7 : 3'($urandom_range(0, 7)));
                write_reg(bmm_pkg::REG_MATCH_EXACT,
                          {2'($urandom_range(0, 3)), 1'($urandom_range(0, 99) < 70)});
            end
            // some searches run with no sender idling at all
            send_idle_pct = ($urandom_range(0, 4) == 0) ? 0 : sender_idle;
            run_search();
            nsearch++;
        end
        send_idle_pct = sender_idle;
    endtask

    initial begin
        for (int i = 0; i < bmm_pkg::MAX_PATTERN; i++) pat_syms[i] = '0;
        for (int e = 0; e < bmm_pkg::MAX_ROWS; e++) row_state[e] = '0;
        for (int i = 0; i < 4; i++) search_alpha[i] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_pattern();
        test_exact_extremes();
        test_overhang_ticks();
        test_code_mode();
        test_full_pattern();
        test_random_traffic(0, 0, 220);
        test_random_traffic(72, 0, 220);
        test_random_traffic(0, 72, 220);
        test_random_traffic(28, 28, 220);

        go_quiet();
        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
src/bmm_pkg.sv
src/bmm_pattern.sv
src/bitap_mismatch_matcher.sv
sim/tb.sv
